// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the multi-channel byte FIFO RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define MCBF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: always");

// Consequent holds in the same cycle as the antecedent.
`define MCBF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle");

// Consequent holds in the cycle after the antecedent.
`define MCBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");

`endif

// ===== rtl/mcbf_pkg.sv =====
// Package: sizes, command codes and control structs of the byte FIFO.
package mcbf_pkg;

  localparam int CHANNELS = 4;
  localparam int DEPTH    = 16;

  localparam int CMD_W  = 2;
  localparam int CH_W   = 2;
  localparam int BYTE_W = 8;
  localparam int LVL_W  = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Per-channel request from the top level.
  typedef struct packed {
    logic push;
    logic pop;
  } lane_ctl_t;

  // Per-channel status back to the top level.
  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [BYTE_W-1:0] head;
  } lane_sts_t;

  // Per-cell load and shift strobes.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic              refused;
    logic [BYTE_W-1:0] data_out;
    logic              now_empty;
  } result_t;

endpackage

// ===== rtl/mcbf_if.sv =====
// Valid/ready channel interfaces for the byte FIFO input and result items.
interface mcbf_in_if;
  logic                          valid;
  logic                          ready;
  logic [mcbf_pkg::CMD_W-1:0]    cmd;
  logic [mcbf_pkg::CH_W-1:0]     channel;
  logic [mcbf_pkg::BYTE_W-1:0]   data_in;

  modport source (output valid, cmd, channel, data_in, input ready);
  modport sink   (input valid, cmd, channel, data_in, output ready);
endinterface

interface mcbf_out_if;
  logic                          valid;
  logic                          ready;
  logic                          refused;
  logic [mcbf_pkg::BYTE_W-1:0]   data_out;
  logic                          now_empty;

  modport source (output valid, refused, data_out, now_empty, input ready);
  modport sink   (input valid, refused, data_out, now_empty, output ready);
endinterface

// ===== rtl/mcbf_cell.sv =====
// One byte cell of a channel chain: load from input or take neighbor byte.
module mcbf_cell (
  input  logic                        clk,
  input  mcbf_pkg::cell_ctl_t         ctl,
  input  logic [mcbf_pkg::BYTE_W-1:0] din,
  input  logic [mcbf_pkg::BYTE_W-1:0] next_data,
  output logic [mcbf_pkg::BYTE_W-1:0] data
);
  import mcbf_pkg::*;

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = din;
    end else if (ctl.shift) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/mcbf_lane.sv =====
// One channel: a chain of byte cells with its head at cell 0 and a fill count.
`include "assert_macros.svh"

module mcbf_lane (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcbf_pkg::lane_ctl_t         ctl,
  input  logic [mcbf_pkg::BYTE_W-1:0] din,
  output mcbf_pkg::lane_sts_t         sts
);
  import mcbf_pkg::*;

  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  level_nxt;
  logic              full;
  logic              push_ok;
  logic              pop_ok;
  logic [BYTE_W-1:0] cell_q [DEPTH];

  assign full    = (level_r == LVL_W'(DEPTH));
  assign push_ok = ctl.push && !full;
  assign pop_ok  = ctl.pop && (level_r != '0);

  always_comb begin
    level_nxt = level_r;
    if (push_ok) begin
      level_nxt = level_r + LVL_W'(1);
    end else if (pop_ok) begin
      level_nxt = level_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  // Push lands in the first free cell; pop moves every byte one cell toward the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctl_t         c_ctl;
    logic [BYTE_W-1:0] c_next;

    assign c_ctl.load  = push_ok && (level_r == LVL_W'(i));
    assign c_ctl.shift = pop_ok;

    if (i == DEPTH - 1) begin : g_tail
      assign c_next = din;
    end else begin : g_mid
      assign c_next = cell_q[i+1];
    end

    mcbf_cell u_cell (
      .clk       (clk),
      .ctl       (c_ctl),
      .din       (din),
      .next_data (c_next),
      .data      (cell_q[i])
    );
  end

  assign sts.level = level_r;
  assign sts.head  = cell_q[0];

  `MCBF_ASSERT_ALWAYS(a_level_bound, level_r <= LVL_W'(DEPTH))
  `MCBF_ASSERT_NEXT(a_push_count, push_ok, level_r == LVL_W'($past(level_r) + LVL_W'(1)))
  `MCBF_ASSERT_NEXT(a_pop_count, pop_ok, level_r == LVL_W'($past(level_r) - LVL_W'(1)))
  `MCBF_ASSERT_NEXT(a_push_empty_head, push_ok && (level_r == '0), cell_q[0] == $past(din))

endmodule

// ===== rtl/multi_channel_byte_fifo.sv =====
// Top level of the multi-channel byte FIFO: decode, per-channel cell chains, result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  in_ch   | in  | valid/ready        | cmd[1:0], channel[1:0], data_in[7:0]
//  out_ch  | out | valid/ready        | refused, data_out[7:0], now_empty
//
// One item per cycle when not held off: an item is decoded against the current
// fill count and head cell of its channel and the result is captured in the output
// register at the edge that accepts it, so the result shows in the next cycle.
// The input is held off only while a result waits in the output register
// and the sink is not taking it. Reset clears all fill counts; cell bytes are
// not reset and are only seen after a push wrote them.
`include "assert_macros.svh"

module multi_channel_byte_fifo (
  input  logic   clk,
  input  logic   rst_n,
  mcbf_in_if.sink    in_ch,
  mcbf_out_if.source out_ch
);
  import mcbf_pkg::*;

  logic              accept;
  logic              ch_ok;
  cmd_t              cmd;
  logic [LVL_W-1:0]  sel_level;
  logic [BYTE_W-1:0] sel_head;
  logic              sel_empty;
  logic              sel_full;
  result_t           res;
  result_t           res_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  lane_ctl_t         lane_ctl [CHANNELS];
  lane_sts_t         lane_sts [CHANNELS];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.cmd);
  assign ch_ok       = (32'(in_ch.channel) < CHANNELS);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    assign lane_ctl[c].push = accept && (32'(in_ch.channel) == c) && (cmd == CMD_PUSH);
    assign lane_ctl[c].pop  = accept && (32'(in_ch.channel) == c) && (cmd == CMD_POP);

    mcbf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl[c]),
      .din   (in_ch.data_in),
      .sts   (lane_sts[c])
    );
  end

  always_comb begin
    sel_level = '0;
    sel_head  = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (32'(in_ch.channel) == c) begin
        sel_level = lane_sts[c].level;
        sel_head  = lane_sts[c].head;
      end
    end
  end

  assign sel_empty = (sel_level == '0);
  assign sel_full  = (sel_level == LVL_W'(DEPTH));

  always_comb begin
    res.refused   = 1'b1;
    res.data_out  = '0;
    res.now_empty = 1'b1;
    if (ch_ok) begin
      unique case (cmd)
        CMD_PUSH: begin
          res.refused   = sel_full;
          res.now_empty = 1'b0;
        end
        CMD_POP: begin
          if (!sel_empty) begin
            res.refused   = 1'b0;
            res.data_out  = sel_head;
            res.now_empty = (sel_level == LVL_W'(1));
          end
        end
        CMD_QUERY: begin
          if (!sel_empty) begin
            res.refused   = 1'b0;
            res.data_out  = sel_head;
            res.now_empty = 1'b0;
          end
        end
        default: begin
          res.now_empty = sel_empty;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.refused   = res_r.refused;
  assign out_ch.data_out  = res_r.data_out;
  assign out_ch.now_empty = res_r.now_empty;

  `MCBF_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_r)
  `MCBF_ASSERT_SAME(a_refused_no_data, out_valid_r && res_r.refused, res_r.data_out == '0)
  `MCBF_ASSERT_SAME(a_no_overwrite, accept, !out_valid_r || out_ch.ready)

endmodule

// ===== tb/multi_channel_byte_fifo_checker.sv =====
// Checker for the multi-channel byte FIFO: predicts each result and compares it in order.
`timescale 1ns / 100ps

module multi_channel_byte_fifo_checker (
  input  logic clk,
  input  logic rst_n,
  mcbf_in_if   in_mon,
  mcbf_out_if  out_mon,
  output int   mismatches,
  output int   outstanding
);
  import mcbf_pkg::*;

  logic [BYTE_W-1:0] lane_bytes [CHANNELS][DEPTH];
  int unsigned       lane_fill  [CHANNELS];
  int unsigned       lane_head  [CHANNELS];
  result_t           expected_results [$];
  result_t           got;
  result_t           want;
  int                err_cnt = 0;

  // Apply one command to the model queues and return the result it produces.
  function automatic result_t fifo_step(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch,
                                        logic [BYTE_W-1:0] din);
    result_t     r;
    int unsigned slot;
    r.refused   = 1'b1;
    r.data_out  = '0;
    r.now_empty = 1'b1;
    if (int'(ch) >= CHANNELS) return r;
    if (cmd == CMD_PUSH) begin
      r.now_empty = 1'b0;
      if (lane_fill[ch] >= DEPTH) return r;
      slot = lane_head[ch] + lane_fill[ch];
      if (slot >= DEPTH) slot = slot - DEPTH;
      lane_bytes[ch][slot] = din;
      lane_fill[ch]++;
      r.refused = 1'b0;
    end else if (cmd == CMD_POP || cmd == CMD_QUERY) begin
      if (lane_fill[ch] == 0) return r;
      r.refused  = 1'b0;
      r.data_out = lane_bytes[ch][lane_head[ch]];
      if (cmd == CMD_POP) begin
        lane_head[ch] = (lane_head[ch] + 1 >= DEPTH) ? 0 : lane_head[ch] + 1;
        lane_fill[ch]--;
      end
      r.now_empty = (lane_fill[ch] == 0);
    end else begin
      // unused command code: report state, change nothing
      r.now_empty = (lane_fill[ch] == 0);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (lane_fill[i]) begin
        lane_fill[i] = 0;
        lane_head[i] = 0;
      end
      expected_results.delete();
    end else begin
      // results first: a result never belongs to an item accepted at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got.refused   = out_mon.refused;
        got.data_out  = out_mon.data_out;
        got.now_empty = out_mon.now_empty;
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result refused=%b data_out=%h now_empty=%b",
                   $time, got.refused, got.data_out, got.now_empty);
        end else begin
          want = expected_results.pop_front();
          if (got.refused !== want.refused || got.data_out !== want.data_out ||
              got.now_empty !== want.now_empty) begin
            err_cnt++;
            $display({"%0t: mismatch expected refused=%b data_out=%h now_empty=%b,",
                      " actual refused=%b data_out=%h now_empty=%b"},
                     $time, want.refused, want.data_out, want.now_empty,
                     got.refused, got.data_out, got.now_empty);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(fifo_step(in_mon.cmd, in_mon.channel, in_mon.data_in));
    end
    outstanding <= expected_results.size();
    mismatches  <= err_cnt;
  end

endmodule

// ===== tb/multi_channel_byte_fifo_tb.sv =====
// Testbench top for the multi-channel byte FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module multi_channel_byte_fifo_tb;
  import mcbf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int               CYCLE_LIMIT = 200000;
  localparam int               PHASE_ITEMS = 188;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   cycles    = 0;
  int   mismatches;
  int   outstanding;

  mcbf_in_if  in_ch ();
  mcbf_out_if out_ch ();

  multi_channel_byte_fifo DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  multi_channel_byte_fifo_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("multi_channel_byte_fifo_tb: errors");
      $finish;
    end
  end

  // Offer one item, with random idle cycles ahead of it, and hold until it is taken.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [CH_W-1:0] ch, logic [BYTE_W-1:0] din);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.channel <= ch;
    in_ch.data_in <= din;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold off the input until every predicted result has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
    int r;
    r = $urandom_range(99);
    if (r < 3) return CMD_UNUSED;
    if (r < 3 + push_pct) return CMD_PUSH;
    if (r < 88) return CMD_POP;
    return CMD_QUERY;
  endfunction

  // Alternate fill and drain bursts aimed mostly at one hot channel.
  task automatic run_random(int count, int idle, int stall);
    int               push_pct;
    logic [CH_W-1:0]  hot_ch;
    logic [CH_W-1:0]  ch;
    idle_pct  = idle;
    stall_pct = stall;
    hot_ch    = CH_W'($urandom_range(CHANNELS - 1));
    push_pct  = 60;
    for (int k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        hot_ch   = CH_W'($urandom_range(CHANNELS - 1));
        push_pct = ((k / 40) % 2 == 0) ? 62 : 22;
      end
      ch = ($urandom_range(99) < 70) ? hot_ch : CH_W'($urandom_range(CHANNELS - 1));
      send_item(pick_cmd(push_pct), ch, BYTE_W'($urandom_range(255)));
    end
    wait_drained();
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_PUSH;
    in_ch.channel = '0;
    in_ch.data_in = '0;
    out_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill one channel to the top, then push once more into the full channel
    for (int i = 0; i < DEPTH; i++)
      send_item(CMD_PUSH, CH_W'(CHANNELS - 1),
                (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : {i[3:0], ~i[3:0]});
    send_item(CMD_PUSH, CH_W'(CHANNELS - 1), 8'h5A);
    send_item(CMD_QUERY, CH_W'(CHANNELS - 1), 8'hFF);
    send_item(CMD_UNUSED, CH_W'(CHANNELS - 1), 8'h00);
    send_item(CMD_POP, CH_W'(CHANNELS - 1), 8'h00);
    // pop, query and unused command on an empty channel
    send_item(CMD_POP, 2'd0, 8'hFF);
    send_item(CMD_QUERY, 2'd0, 8'h00);
    send_item(CMD_UNUSED, 2'd0, 8'hFF);
    send_item(CMD_PUSH, 2'd0, 8'hFF);
    send_item(CMD_POP, 2'd0, 8'h00);
    wait_drained();

    run_random(PHASE_ITEMS, 0, 0);
    run_random(PHASE_ITEMS, 63, 0);
    run_random(PHASE_ITEMS, 0, 63);
    run_random(PHASE_ITEMS, 33, 33);

    stall_pct = 0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("multi_channel_byte_fifo_tb: clean");
    end else begin
      $display("multi_channel_byte_fifo_tb: errors");
    end
    $finish;
  end

endmodule
